### src/lfsm_pkg.sv
package lfsm_pkg;

    localparam int LINE_MAX    = 32;
    localparam int PATTERN_MAX = 16;
    localparam int LINE_AW     = $clog2(LINE_MAX);
    localparam int VALID_W     = $clog2(PATTERN_MAX + 1);
    localparam int PIDX_W      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int LEN_W       = 5;

    typedef logic [7:0] t_byte;

    localparam t_byte BYTE_LF = 8'd10;
    localparam t_byte BYTE_CR = 8'd13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 2'd0,
        CFG_PATTERN_HIGH = 2'd1,
        CFG_PATTERN_LEN  = 2'd2,
        CFG_FRAME_CR     = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE_CR,
        ST_FETCH,
        ST_LOAD,
        ST_LF,
        ST_POST_CR
    } t_state;

    typedef enum logic [1:0] {
        SEL_CR,
        SEL_LF,
        SEL_STORE
    } t_sel;

    typedef struct packed {
        logic in_ready;
        logic take;
        logic clear;
        logic load;
        t_sel sel;
        logic last;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic in_is_lf;
        logic matched;
        logic frame;
        logic body_done;
        logic body_last;
        logic out_free;
    } t_status;

endpackage

### src/lfsm_in_if.sv
interface lfsm_in_if;
    import lfsm_pkg::*;

    logic  valid;
    logic  ready;
    t_byte data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

### src/lfsm_out_if.sv
interface lfsm_out_if;
    import lfsm_pkg::*;

    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  last_of_line;

    modport source (output valid, output out_byte, output last_of_line, input ready);
    modport sink   (input valid, input out_byte, input last_of_line, output ready);
endinterface

### src/lfsm_ctrl.sv
module lfsm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  lfsm_pkg::t_status i_status,
    output lfsm_pkg::t_cmd    o_cmd
);
    import lfsm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.in_is_lf && i_status.matched) begin
                    if (i_status.frame) begin
                        n_state = ST_PRE_CR;
                    end else if (i_status.body_done) begin
                        n_state = ST_LF;
                    end else begin
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_PRE_CR: begin
                if (i_status.out_free) begin
                    n_state = i_status.body_done ? ST_LF : ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_status.out_free) begin
                    n_state = i_status.body_last ? ST_LF : ST_FETCH;
                end
            end
            ST_LF: begin
                if (i_status.out_free) begin
                    n_state = i_status.frame ? ST_POST_CR : ST_IDLE;
                end
            end
            ST_POST_CR: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '{in_ready: 1'b0, take: 1'b0, clear: 1'b0, load: 1'b0,
                  sel: SEL_CR, last: 1'b0, step: 1'b0};
        case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take  = !i_status.in_is_lf;
                    o_cmd.clear = i_status.in_is_lf && !i_status.matched;
                end
            end
            ST_PRE_CR: begin
                o_cmd.load = i_status.out_free;
                o_cmd.sel  = SEL_CR;
            end
            ST_LOAD: begin
                o_cmd.load = i_status.out_free;
                o_cmd.sel  = SEL_STORE;
                o_cmd.step = i_status.out_free;
            end
            ST_LF: begin
                o_cmd.load  = i_status.out_free;
                o_cmd.sel   = SEL_LF;
                o_cmd.last  = !i_status.frame;
                o_cmd.clear = i_status.out_free && !i_status.frame;
            end
            ST_POST_CR: begin
                o_cmd.load  = i_status.out_free;
                o_cmd.sel   = SEL_CR;
                o_cmd.last  = 1'b1;
                o_cmd.clear = i_status.out_free;
            end
            default: begin
                o_cmd.in_ready = 1'b0;
            end
        endcase
    end

endmodule

### src/lfsm_dp.sv
module lfsm_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lfsm_pkg::t_byte                 i_data_byte,
    input  logic                            i_cfg_we,
    input  logic [lfsm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lfsm_pkg::CFG_W-1:0]      i_cfg_data,
    input  lfsm_pkg::t_cmd                  i_cmd,
    output lfsm_pkg::t_status               o_status,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output lfsm_pkg::t_byte                 o_out_byte,
    output logic                            o_out_last
);
    import lfsm_pkg::*;

    logic [CFG_W-1:0]   r_pat_low;
    logic [CFG_W-1:0]   r_pat_high;
    logic [LEN_W-1:0]   r_pat_len;
    logic               r_frame;

    t_byte              r_mem [LINE_MAX];
    t_byte              r_rd;
    logic [LINE_AW-1:0] r_fill;
    logic [LINE_AW-1:0] r_k;
    t_byte              r_win [PATTERN_MAX];
    t_byte              n_win [PATTERN_MAX];
    logic [VALID_W-1:0] r_valid;
    logic [VALID_W-1:0] n_valid;
    logic               r_matched;

    logic               r_out_valid;
    t_byte              r_out_byte;
    logic               r_out_last;

    t_byte              pat [PATTERN_MAX];
    logic [VALID_W-1:0] act_len;
    logic [VALID_W-1:0] pidx;
    logic               hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= LEN_W'(1);
            r_frame    <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PATTERN_LOW:  r_pat_low  <= i_cfg_data;
                CFG_PATTERN_HIGH: r_pat_high <= i_cfg_data;
                CFG_PATTERN_LEN:  r_pat_len  <= i_cfg_data[LEN_W-1:0];
                CFG_FRAME_CR:     r_frame    <= i_cfg_data[0];
                default:          r_frame    <= r_frame;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (k < 8) begin
                pat[k] = r_pat_low[8*(k%8) +: 8];
            end else begin
                pat[k] = r_pat_high[8*(k%8) +: 8];
            end
        end
        if (r_pat_len == '0) begin
            act_len = VALID_W'(1);
        end else if (r_pat_len > LEN_W'(PATTERN_MAX)) begin
            act_len = VALID_W'(PATTERN_MAX);
        end else begin
            act_len = VALID_W'(r_pat_len);
        end
    end

    // window shift and substring check on the updated window
    always_comb begin
        n_win[0] = i_data_byte;
        for (int j = 1; j < PATTERN_MAX; j++) begin
            n_win[j] = r_win[j-1];
        end
        n_valid = (r_valid == VALID_W'(PATTERN_MAX)) ? r_valid : r_valid + 1'b1;
        hit     = (n_valid >= act_len);
        pidx    = '0;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if (VALID_W'(j) < act_len) begin
                pidx = act_len - VALID_W'(1) - VALID_W'(j);
                if (n_win[j] != pat[pidx[PIDX_W-1:0]]) begin
                    hit = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                r_win[j] <= n_win[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (r_fill < LINE_AW'(LINE_MAX - 1))) begin
            r_mem[r_fill] <= i_data_byte;
        end
        r_rd <= r_mem[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_fill    <= '0;
            r_k       <= '0;
            r_valid   <= '0;
            r_matched <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                if (r_fill < LINE_AW'(LINE_MAX - 1)) begin
                    r_fill <= r_fill + 1'b1;
                end
                r_valid   <= n_valid;
                r_matched <= r_matched | hit;
            end
            if (i_cmd.step) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_last <= i_cmd.last;
            case (i_cmd.sel)
                SEL_CR:    r_out_byte <= BYTE_CR;
                SEL_LF:    r_out_byte <= BYTE_LF;
                SEL_STORE: r_out_byte <= r_rd;
                default:   r_out_byte <= r_rd;
            endcase
        end
    end

    always_comb begin
        o_status.in_is_lf  = (i_data_byte == BYTE_LF);
        o_status.matched   = r_matched;
        o_status.frame     = r_frame;
        o_status.body_done = (r_k == r_fill);
        o_status.body_last = (LINE_AW'(r_k + 1'b1) == r_fill);
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

### src/line_filter_substring_match_top.sv
// Channel   Dir   Handshake          Payload
// i_in_ch   in    valid / ready      data_byte[7:0]
// o_out_ch  out   valid / ready      out_byte[7:0], last_of_line
// i_cfg     in    i_cfg_we (no wait) i_cfg_index[1:0], i_cfg_data[63:0]
//
// A text byte or a non-matching line feed is taken while idle; input stays ready.
// A matching line holds input off while it is emitted: each stored byte passes
// FETCH then LOAD (line store read is registered); LF and CR load directly.
// Synchronous active-low reset clears config, line state and output valid.
// Output is a single register; a stalled output holds the emitter in place.
module line_filter_substring_match_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lfsm_in_if.sink                         i_in_ch,
    lfsm_out_if.source                      o_out_ch,
    input  logic                            i_cfg_we,
    input  logic [lfsm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lfsm_pkg::CFG_W-1:0]      i_cfg_data
);
    import lfsm_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign i_in_ch.ready = cmd.in_ready;

    lfsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lfsm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_in_ch.data_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (o_out_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .o_out_byte  (o_out_ch.out_byte),
        .o_out_last  (o_out_ch.last_of_line)
    );

endmodule

### bench/tb.sv
module tb;
    import lfsm_pkg::*;

    localparam int TOTAL_ITEMS  = 410;
    localparam int CALM_AFTER   = 340;
    localparam int PHASE_ITEMS  = 55;
    localparam int SETTLE_TAIL  = 8;
    localparam int RUN_LIMIT    = 5_000_000;

    typedef struct {
        t_byte data;
        logic  last;
    } t_emit;

    class matched_line_board;
        t_byte      pat[PATTERN_MAX];
        logic [4:0] pat_len;
        bit         framed;
        t_byte      line_buf[$];
        t_byte      window[PATTERN_MAX];
        int         window_fill;
        bit         seen;
        t_emit      due_bytes[$];
        int         mismatches;

        function new();
            foreach (pat[k]) pat[k] = 8'h00;
            pat_len    = 5'd1;
            framed     = 1'b0;
            mismatches = 0;
            clear_line();
        endfunction

        function void clear_line();
            line_buf.delete();
            foreach (window[k]) window[k] = 8'h00;
            window_fill = 0;
            seen        = 1'b0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] v);
            case (idx)
                CFG_PATTERN_LOW: begin
                    for (int k = 0; k < 8; k++) pat[k] = v[8*k +: 8];
                end
                CFG_PATTERN_HIGH: begin
                    for (int k = 0; k < 8; k++) pat[8+k] = v[8*k +: 8];
                end
                CFG_PATTERN_LEN: pat_len = v[4:0];
                CFG_FRAME_CR:    framed  = v[0];
                default: ;
            endcase
        endfunction

        function int eff_len();
            int n;
            n = int'(pat_len);
            if (n == 0) n = 1;
            if (n > PATTERN_MAX) n = PATTERN_MAX;
            return n;
        endfunction

        function int pending();
            return due_bytes.size();
        endfunction

        function void note_input(t_byte b);
            int n;
            int j;
            bit hit;
            if (b != BYTE_LF) begin
                if (line_buf.size() < LINE_MAX - 1) line_buf.push_back(b);
                for (j = PATTERN_MAX - 1; j > 0; j--) window[j] = window[j-1];
                window[0] = b;
                if (window_fill < PATTERN_MAX) window_fill++;
                n = eff_len();
                if (window_fill >= n) begin
                    hit = 1'b1;
                    for (j = 0; j < n; j++)
                        if (window[j] != pat[n-1-j]) hit = 1'b0;
                    if (hit) seen = 1'b1;
                end
            end else begin
                if (seen) begin
                    if (framed) due_bytes.push_back('{BYTE_CR, 1'b0});
                    foreach (line_buf[k]) due_bytes.push_back('{line_buf[k], 1'b0});
                    due_bytes.push_back('{BYTE_LF, 1'b0});
                    if (framed) due_bytes.push_back('{BYTE_CR, 1'b0});
                    due_bytes[due_bytes.size()-1].last = 1'b1;
                end
                clear_line();
            end
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            mismatches++;
        endtask

        task check_result(t_byte got_b, logic got_last);
            t_emit want;
            if (due_bytes.size() == 0) begin
                report($sformatf("unexpected item out_byte=%02h last=%b", got_b, got_last));
                return;
            end
            want = due_bytes.pop_front();
            if (got_b !== want.data)
                report($sformatf("out_byte %02h, want %02h", got_b, want.data));
            if (got_last !== want.last)
                report($sformatf("last_of_line %b, want %b (byte %02h)",
                                 got_last, want.last, want.data));
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    lfsm_in_if  in_ch ();
    lfsm_out_if out_ch ();

    line_filter_substring_match_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    matched_line_board board;
    t_byte line_q[$];
    int    items_sent;
    int    sink_hold;
    bit    gaps_on;
    bit    stalls_on;
    bit    calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #RUN_LIMIT;
        $display("line_filter_substring_match_top verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (calm || !stalls_on) begin
            out_ch.ready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold--;
            out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            sink_hold = $urandom_range(0, 9);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            board.check_result(out_ch.out_byte, out_ch.last_of_line);
    end

    task send_byte(t_byte b);
        if (gaps_on && !calm && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        board.note_input(b);
        items_sent++;
    endtask

    task send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(t_byte'(s[i]));
    endtask

    // waits out every due byte, then the block's tail
    task settle();
        in_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_TAIL) @(posedge i_clk);
    endtask

    task write_reg(t_cfg_idx idx, logic [CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        board.write_reg(idx, v);
    endtask

    task load_config(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi,
                     logic [CFG_W-1:0] len, logic [CFG_W-1:0] frame);
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_PATTERN_LEN, len);
        write_reg(CFG_FRAME_CR, frame);
        i_cfg_we <= 1'b0;
    endtask

    function t_byte any_text_byte();
        t_byte b;
        b = t_byte'($urandom_range(0, 255));
        if (b == BYTE_LF) b = 8'hF5;
        return b;
    endfunction

    function t_byte filler_byte();
        if ($urandom_range(0, 1) == 0)
            return board.pat[$urandom_range(0, board.eff_len() - 1)];
        return any_text_byte();
    endfunction

    task random_config(int kind);
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        logic [CFG_W-1:0] len;
        logic [CFG_W-1:0] frame;
        t_byte pb;
        lo    = '0;
        hi    = '0;
        len   = {$urandom, $urandom};
        frame = {$urandom, $urandom};
        case (kind % 6)
            0: begin
                lo    = '1;
                hi    = '1;
                len   = '1;
                frame = '1;
            end
            1: begin
                len   = '0;
                frame = '0;
            end
            default: begin
                for (int k = 0; k < PATTERN_MAX; k++) begin
                    pb = ($urandom_range(0, 3) == 0) ? any_text_byte()
                                                     : t_byte'(8'h61 + $urandom_range(0, 2));
                    if (k < 8) lo[8*k +: 8] = pb;
                    else       hi[8*(k-8) +: 8] = pb;
                end
                case (kind % 6)
                    2:       len[4:0] = 5'($urandom_range(1, 3));
                    3:       len[4:0] = 5'($urandom_range(4, 16));
                    4:       len[4:0] = 5'($urandom_range(17, 31));
                    default: len[4:0] = 5'($urandom_range(1, 2));
                endcase
            end
        endcase
        load_config(lo, hi, len, frame);
    endtask

    // well-formed lines mostly: whole pattern, a near miss, or plain noise
    task build_line();
        int n_text;
        int n_pre;
        int mode;
        int plen;
        int r;
        t_byte miss;
        line_q.delete();
        r = $urandom_range(0, 99);
        if (r < 75)      n_text = $urandom_range(0, 10);
        else if (r < 93) n_text = $urandom_range(11, 30);
        else             n_text = $urandom_range(31, 45);
        plen  = board.eff_len();
        mode  = $urandom_range(0, 9);
        n_pre = $urandom_range(0, n_text);
        repeat (n_pre) line_q.push_back(filler_byte());
        if (mode <= 5) begin
            for (int k = 0; k < plen; k++) line_q.push_back(board.pat[k]);
        end else if (mode <= 7) begin
            for (int k = 0; k < plen - 1; k++) line_q.push_back(board.pat[k]);
            miss = board.pat[plen-1] + 8'd1;
            if (miss == BYTE_LF) miss = miss + 8'd1;
            line_q.push_back(miss);
        end
        repeat (n_text - n_pre) line_q.push_back(filler_byte());
        line_q.push_back(BYTE_LF);
    endtask

    initial begin
        int phase;
        int phase_start;
        board           = new();
        items_sent      = 0;
        sink_hold       = 0;
        gaps_on         = 1'b1;
        stalls_on       = 1'b1;
        calm            = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_PATTERN_LOW;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'h00;
        out_ch.ready    = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: one-byte pattern of zero
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(BYTE_LF);
        send_text("A\n");
        send_text("\n");
        settle();

        // framed, two bytes; pattern split across a line feed must not match
        load_config(64'h6261, 64'h0, 64'd2, 64'd1);
        send_text("xab\n");
        send_text("a\nb\n");
        settle();

        // line feed inside the pattern never matches
        load_config(64'h620A61, 64'h0, 64'd3, 64'd0);
        send_text("ab\n");
        send_text("a\nb\n");
        settle();

        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            random_config(phase);
            gaps_on     = ($urandom_range(0, 3) != 0);
            stalls_on   = ($urandom_range(0, 3) != 0);
            phase_start = items_sent;
            while ((items_sent - phase_start < PHASE_ITEMS || calm) &&
                   items_sent < TOTAL_ITEMS) begin
                if (items_sent >= CALM_AFTER) calm = 1'b1;
                build_line();
                foreach (line_q[k]) send_byte(line_q[k]);
                if (!calm && $urandom_range(0, 19) == 0) begin
                    in_ch.valid <= 1'b0;
                    @(posedge i_clk);
                    while (board.pending() != 0) @(posedge i_clk);
                end
            end
            settle();
            phase++;
        end

        if (board.mismatches == 0)
            $display("line_filter_substring_match_top verification clean");
        else
            $display("line_filter_substring_match_top verification failed");
        $finish;
    end
endmodule

### filelist.f
src/lfsm_pkg.sv
src/lfsm_in_if.sv
src/lfsm_out_if.sv
src/lfsm_ctrl.sv
src/lfsm_dp.sv
src/line_filter_substring_match_top.sv
bench/tb.sv
